[rtl/core/rrts_pkg.sv]
package rrts_pkg;

  // Default number of thread slots.
  localparam int MAX_THREADS_DEF = 16;

  // Event codes carried by an input item.
  typedef enum logic [2:0] {
    KIND_CREATE  = 3'd0,
    KIND_START   = 3'd1,
    KIND_YIELD   = 3'd2,
    KIND_BLOCK   = 3'd3,
    KIND_FINISH  = 3'd4,
    KIND_UNBLOCK = 3'd5
  } kind_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DONE     = 2'd1,
    ST_DEADLOCK = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  // One result item.
  typedef struct packed {
    logic [3:0] running_id;
    logic       running_valid;
    logic [3:0] created_id;
    status_t    status;
  } result_t;

endpackage

[rtl/core/round_robin_thread_scheduler.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   in_kind, in_thread_id
// out_      output     out_valid / out_stall out_running_id, out_running_valid,
//                                            out_created_id, out_status
//
// Each item is decoded and applied to the scheduler state in the cycle it is
// accepted; its result is registered at the output, or in the skid stage
// under a stall. One item per cycle is sustained while out_stall is low, set
// by the single ready-queue port pair. Reset (rst_n low, synchronous) empties
// the ready queue and clears all masks. A stalled output keeps its item; one
// more item is held in the skid stage and in_stall rises only while it is full.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [3:0] in_thread_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_running_id,
  output logic       out_running_valid,
  output logic [3:0] out_created_id,
  output logic [1:0] out_status
);

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);

  logic              accept;
  logic              push_en;
  logic [SLOT_W-1:0] push_data;
  logic              pop_en;
  logic [SLOT_W-1:0] head_data;
  logic [CNT_W-1:0]  count;
  rrts_pkg::result_t result;
  rrts_pkg::result_t out_data;

  assign accept = in_valid && !in_stall;

  // Ready queue of slot numbers.
  rrts_ready_fifo #(
    .MAX_THREADS(MAX_THREADS)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push_data (push_data),
    .pop_en    (pop_en),
    .head_data (head_data),
    .count     (count)
  );

  // Event decode, slot masks and running thread.
  rrts_sched_core #(
    .MAX_THREADS(MAX_THREADS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_kind),
    .thread_id (in_thread_id),
    .head_data (head_data),
    .count     (count),
    .push_en   (push_en),
    .push_data (push_data),
    .pop_en    (pop_en),
    .result    (result)
  );

  // Result register with skid stage.
  rrts_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_running_id    = out_data.running_id;
  assign out_running_valid = out_data.running_valid;
  assign out_created_id    = out_data.created_id;
  assign out_status        = out_data.status;

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid stage full without a waiting result");

  // After every accepted item the output holds a valid result in the next cycle.
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item did not reach the output");

  // No running thread means the running slot reads as zero.
  a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running_valid) |-> (out_running_id == 4'd0))
    else $error("running id set with nothing running");

  // Done and deadlock are only reported with nothing running.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rrts_pkg::ST_DONE ||
                   out_status == rrts_pkg::ST_DEADLOCK)) |-> !out_running_valid)
    else $error("done or deadlock reported while a thread runs");

endmodule

[rtl/core/rrts_ready_fifo.sv]
module rrts_ready_fifo #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push_en,
  input  logic [$clog2(MAX_THREADS)-1:0]     push_data,
  input  logic                               pop_en,
  output logic [$clog2(MAX_THREADS)-1:0]     head_data,
  output logic [$clog2(MAX_THREADS+1)-1:0]   count
);

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);

  logic [SLOT_W-1:0] mem [MAX_THREADS];

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] head_data_r;
  logic              push_ok;
  logic              pop_ok;

  // Guard against overflow and underflow.
  assign push_ok = push_en && (count_r != CNT_W'(MAX_THREADS));
  assign pop_ok  = pop_en && (count_r != '0);

  // Pointer and count updates, wrapping at the slot count.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop_ok) begin
      head_nxt = (head_r == SLOT_W'(MAX_THREADS - 1)) ? '0 : head_r + 1'b1;
    end
    if (push_ok) begin
      tail_nxt = (tail_r == SLOT_W'(MAX_THREADS - 1)) ? '0 : tail_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage; the head entry is read ahead into a register, with the
  // entry being written forwarded when it becomes the new head.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= push_data;
    end
    if (push_ok && (tail_r == head_nxt)) begin
      head_data_r <= push_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign head_data = head_data_r;
  assign count     = count_r;

endmodule

[rtl/core/rrts_sched_core.sv]
module rrts_sched_core #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [2:0]                         kind,
  input  logic [3:0]                         thread_id,
  input  logic [$clog2(MAX_THREADS)-1:0]     head_data,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   count,
  output logic                               push_en,
  output logic [$clog2(MAX_THREADS)-1:0]     push_data,
  output logic                               pop_en,
  output rrts_pkg::result_t                  result
);

  localparam int SLOT_W = $clog2(MAX_THREADS);

  logic [MAX_THREADS-1:0] alloc_r, alloc_nxt;
  logic [MAX_THREADS-1:0] blocked_r, blocked_nxt;
  logic [SLOT_W-1:0]      cur_slot_r, cur_slot_nxt;
  logic                   cur_valid_r, cur_valid_nxt;

  logic [MAX_THREADS-1:0] free_mask;
  logic [SLOT_W-1:0]      free_idx;
  logic [SLOT_W+3:0]      tid_ext;
  logic [SLOT_W-1:0]      tid_idx;
  logic                   tid_in_range;
  logic                   ready_none;
  logic                   push_req;
  logic                   pop_req;
  logic [SLOT_W+3:0]      run_ext;
  logic [SLOT_W+3:0]      new_ext;
  logic [SLOT_W-1:0]      created_slot;
  rrts_pkg::status_t      status;

  // Lowest free slot.
  assign free_mask = ~alloc_r;
  always_comb begin
    free_idx = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign tid_ext      = {{SLOT_W{1'b0}}, thread_id};
  assign tid_idx      = tid_ext[SLOT_W-1:0];
  assign tid_in_range = 32'(thread_id) < 32'(MAX_THREADS);
  assign ready_none   = (count == '0);

  // Event decode and state update for one item.
  always_comb begin
    alloc_nxt     = alloc_r;
    blocked_nxt   = blocked_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    status        = rrts_pkg::ST_INVALID;
    created_slot  = '0;
    push_req      = 1'b0;
    push_data     = '0;
    pop_req       = 1'b0;
    case (kind)
      rrts_pkg::KIND_CREATE: begin
        if (|free_mask) begin
          alloc_nxt[free_idx] = 1'b1;
          push_req            = 1'b1;
          push_data           = free_idx;
          created_slot        = free_idx;
          status              = rrts_pkg::ST_OK;
        end
      end
      rrts_pkg::KIND_START, rrts_pkg::KIND_BLOCK, rrts_pkg::KIND_FINISH: begin
        if (kind == rrts_pkg::KIND_START ? !cur_valid_r : cur_valid_r) begin
          if (kind == rrts_pkg::KIND_BLOCK) begin
            blocked_nxt[cur_slot_r] = 1'b1;
          end
          if (kind == rrts_pkg::KIND_FINISH) begin
            alloc_nxt[cur_slot_r] = 1'b0;
          end
          // Dispatch the ready head, or report why nothing runs.
          if (ready_none) begin
            cur_valid_nxt = 1'b0;
            cur_slot_nxt  = '0;
            status = (|blocked_nxt) ? rrts_pkg::ST_DEADLOCK : rrts_pkg::ST_DONE;
          end else begin
            cur_valid_nxt = 1'b1;
            cur_slot_nxt  = head_data;
            pop_req       = 1'b1;
            status        = rrts_pkg::ST_OK;
          end
        end
      end
      rrts_pkg::KIND_YIELD: begin
        // With an empty queue the running thread is picked again.
        if (cur_valid_r) begin
          status = rrts_pkg::ST_OK;
          if (!ready_none) begin
            push_req     = 1'b1;
            push_data    = cur_slot_r;
            pop_req      = 1'b1;
            cur_slot_nxt = head_data;
          end
        end
      end
      rrts_pkg::KIND_UNBLOCK: begin
        if (tid_in_range && blocked_r[tid_idx]) begin
          blocked_nxt[tid_idx] = 1'b0;
          push_req             = 1'b1;
          push_data            = tid_idx;
          status               = rrts_pkg::ST_OK;
        end
      end
      default: begin
        status = rrts_pkg::ST_INVALID;
      end
    endcase
  end

  assign push_en = accept && push_req;
  assign pop_en  = accept && pop_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      blocked_r   <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
    end else if (accept) begin
      alloc_r     <= alloc_nxt;
      blocked_r   <= blocked_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
    end
  end

  // Result fields are four bits wide whatever the slot count.
  assign run_ext = {4'b0000, cur_slot_nxt};
  assign new_ext = {4'b0000, created_slot};

  always_comb begin
    result.running_id    = cur_valid_nxt ? run_ext[3:0] : 4'd0;
    result.running_valid = cur_valid_nxt;
    result.created_id    = new_ext[3:0];
    result.status        = status;
  end

endmodule

[rtl/core/rrts_out_buf.sv]
module rrts_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rrts_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rrts_pkg::result_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  rrts_pkg::result_t out_data_r;
  rrts_pkg::result_t skid_data_r;
  logic              accept;
  logic              out_free;

  // A new item is taken as long as the skid stage is empty.
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || accept;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload moves: skid first, then the new item.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end else if (accept) begin
      skid_data_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
